// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int KEY_W_DEF  = 16;
    localparam int PRIO_W_DEF = 16;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 7;

    // Operation codes carried by each transaction.
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 3'd0,
        FN_EXTRACT = 3'd1,
        FN_REMOVE  = 3'd2,
        FN_CHANGE  = 3'd3,
        FN_CLEAR   = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_RECMP
    } t_state;

    // What each slot compares against the broadcast operand.
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INS,
        CM_DEL_KEY,
        CM_DEL_HEAD
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       capture;
        logic       ins_move;
        logic       del_move;
    } t_cell_ctl;

endpackage

// ===== design/sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// command   in         start, busy          i_func, i_item_key, i_item_priority
// result    out        o_done (strobe)      o_out_key, o_out_priority, o_status,
//                                           o_occupancy
//
// Insert, extract, remove, clear, unused codes and a failed change make a single pass
// between accepted transactions; a change of a present key makes a delete pass, then an
// insert pass. Each pass compares every slot and latches the match flags, then shifts the
// row; the one-cycle o_done strobe rises as the shift lands.
// The synchronous active-low reset clears the count, flags and controller; slot contents
// need no clearing since only occupied slots are ever read. The receiver cannot stall.

module sorted_priority_queue_top #(
    parameter int DEPTH          = spq_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH      = spq_pkg::KEY_W_DEF,
    parameter int PRIORITY_WIDTH = spq_pkg::PRIO_W_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [spq_pkg::FUNC_W-1:0]   i_func,
    input  logic [KEY_WIDTH-1:0]         i_item_key,
    input  logic [PRIORITY_WIDTH-1:0]    i_item_priority,
    output logic                         o_done,
    output logic [KEY_WIDTH-1:0]         o_out_key,
    output logic [PRIORITY_WIDTH-1:0]    o_out_priority,
    output logic [spq_pkg::STATUS_W-1:0] o_status,
    output logic [spq_pkg::OCC_W-1:0]    o_occupancy
);
    import spq_pkg::*;

    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    t_state                    r_state;
    t_state                    n_state;
    logic [CNT_WIDTH-1:0]      r_count;
    logic [CNT_WIDTH-1:0]      n_count;
    logic [FUNC_W-1:0]         r_func;
    logic [FUNC_W-1:0]         n_func;
    logic [KEY_WIDTH-1:0]      r_key;
    logic [KEY_WIDTH-1:0]      n_key;
    logic [PRIORITY_WIDTH-1:0] r_prio;
    logic [PRIORITY_WIDTH-1:0] n_prio;
    logic                      r_full;
    logic                      n_full;
    logic                      r_empty;
    logic                      n_empty;
    logic                      r_done;
    logic                      n_done;
    logic [KEY_WIDTH-1:0]      r_out_key;
    logic [KEY_WIDTH-1:0]      n_out_key;
    logic [PRIORITY_WIDTH-1:0] r_out_prio;
    logic [PRIORITY_WIDTH-1:0] n_out_prio;
    t_status                   r_status;
    t_status                   n_status;
    logic [OCC_W-1:0]          r_occ;
    logic [OCC_W+CNT_WIDTH-1:0] w_occ_ext;

    t_cell_ctl                 w_ctl;
    logic [KEY_WIDTH-1:0]      w_bus_key;
    logic [PRIORITY_WIDTH-1:0] w_bus_prio;
    logic [KEY_WIDTH-1:0]      w_head_key;
    logic [PRIORITY_WIDTH-1:0] w_head_prio;
    logic                      w_found;

    assign busy = (r_state != S_IDLE);

    // While idle the row compares against the command ports, so the match
    // flags are latched at the very edge that takes the transaction. Later
    // the latched operand is broadcast for the shift and for the second pass
    // of a change.
    assign w_bus_key  = (r_state == S_IDLE) ? i_item_key      : r_key;
    assign w_bus_prio = (r_state == S_IDLE) ? i_item_priority : r_prio;

    spq_chain #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PRIORITY_WIDTH(PRIORITY_WIDTH),
        .CNT_WIDTH     (CNT_WIDTH)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_bus_key  (w_bus_key),
        .i_bus_prio (w_bus_prio),
        .i_count    (r_count),
        .o_head_key (w_head_key),
        .o_head_prio(w_head_prio),
        .o_found    (w_found)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_func     = r_func;
        n_key      = r_key;
        n_prio     = r_prio;
        n_full     = r_full;
        n_empty    = r_empty;
        n_done     = 1'b0;
        n_out_key  = '0;
        n_out_prio = '0;
        n_status   = ST_OK;
        w_ctl      = '{mode: CM_HOLD, capture: 1'b0, ins_move: 1'b0, del_move: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state       = S_MOVE;
                    n_func        = i_func;
                    n_key         = i_item_key;
                    n_prio        = i_item_priority;
                    n_full        = (r_count == CNT_WIDTH'(DEPTH));
                    n_empty       = (r_count == '0);
                    w_ctl.capture = 1'b1;
                    case (i_func)
                        FN_INSERT:  w_ctl.mode = n_full ? CM_HOLD : CM_INS;
                        FN_EXTRACT: w_ctl.mode = n_empty ? CM_HOLD : CM_DEL_HEAD;
                        FN_REMOVE:  w_ctl.mode = CM_DEL_KEY;
                        FN_CHANGE:  w_ctl.mode = CM_DEL_KEY;
                        default:    w_ctl.mode = CM_HOLD;
                    endcase
                end
            end

            S_RECMP: begin
                // Second half of a change: the old entry is gone, so the
                // reinsert always finds room.
                w_ctl.capture = 1'b1;
                w_ctl.mode    = CM_INS;
                n_func        = FN_INSERT;
                n_full        = 1'b0;
                n_state       = S_MOVE;
            end

            S_MOVE: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_func)
                    FN_INSERT: begin
                        if (r_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_ctl.ins_move = 1'b1;
                            n_count        = r_count + CNT_WIDTH'(1);
                        end
                    end
                    FN_EXTRACT: begin
                        if (r_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            w_ctl.del_move = 1'b1;
                            n_out_key      = w_head_key;
                            n_out_prio     = w_head_prio;
                            n_count        = r_count - CNT_WIDTH'(1);
                        end
                    end
                    FN_REMOVE: begin
                        if (w_found) begin
                            w_ctl.del_move = 1'b1;
                            n_count        = r_count - CNT_WIDTH'(1);
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    FN_CHANGE: begin
                        if (w_found) begin
                            w_ctl.del_move = 1'b1;
                            n_count        = r_count - CNT_WIDTH'(1);
                            n_state        = S_RECMP;
                            n_done         = 1'b0;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    FN_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_count = r_count;
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_occ_ext = {{OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_prio     <= n_prio;
        r_full     <= n_full;
        r_empty    <= n_empty;
        r_out_key  <= n_out_key;
        r_out_prio <= n_out_prio;
        r_status   <= n_status;
        r_occ      <= w_occ_ext[OCC_W-1:0];
    end

    assign o_done         = r_done;
    assign o_out_key      = r_out_key;
    assign o_out_priority = r_out_prio;
    assign o_status       = r_status;
    assign o_occupancy    = r_occ;

    // A result strobe lasts a single cycle: every path back to a result
    // passes through at least one more shift or compare.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // The controller only returns to idle by delivering a result.
    a_idle_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("returned to idle without a result");

    // The occupancy count never passes the number of slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_WIDTH'(DEPTH))
        else $error("occupancy count beyond depth");

    // A dropped insert is only reported when every slot is taken.
    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (r_count == CNT_WIDTH'(DEPTH)))
        else $error("full reported while a slot is free");

endmodule

// ===== design/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell #(
    parameter int KEY_WIDTH      = spq_pkg::KEY_W_DEF,
    parameter int PRIORITY_WIDTH = spq_pkg::PRIO_W_DEF,
    parameter int CNT_WIDTH      = 7,
    parameter int INDEX          = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  spq_pkg::t_cell_ctl        i_ctl,
    input  logic [KEY_WIDTH-1:0]      i_bus_key,
    input  logic [PRIORITY_WIDTH-1:0] i_bus_prio,
    input  logic [CNT_WIDTH-1:0]      i_count,
    input  logic [KEY_WIDTH-1:0]      i_left_key,
    input  logic [PRIORITY_WIDTH-1:0] i_left_prio,
    input  logic                      i_left_flag,
    input  logic                      i_left_hit,
    input  logic [KEY_WIDTH-1:0]      i_right_key,
    input  logic [PRIORITY_WIDTH-1:0] i_right_prio,
    output logic [KEY_WIDTH-1:0]      o_key,
    output logic [PRIORITY_WIDTH-1:0] o_prio,
    output logic                      o_flag,
    output logic                      o_hit
);
    import spq_pkg::*;

    logic [KEY_WIDTH-1:0]      r_key;
    logic [KEY_WIDTH-1:0]      n_key;
    logic [PRIORITY_WIDTH-1:0] r_prio;
    logic [PRIORITY_WIDTH-1:0] n_prio;
    logic                      r_flag;
    logic                      n_flag;
    logic                      w_valid;
    logic                      w_match;

    assign w_valid = (i_count > CNT_WIDTH'(INDEX));

    always_comb begin
        case (i_ctl.mode)
            CM_INS:      w_match = !w_valid || (r_prio >= i_bus_prio);
            CM_DEL_KEY:  w_match = w_valid && (r_key == i_bus_key);
            CM_DEL_HEAD: w_match = 1'b1;
            default:     w_match = 1'b0;
        endcase
    end

    // The hit chain is an OR prefix: a slot is marked when it or any slot
    // in front of it matched.
    assign o_hit  = i_left_hit | w_match;
    assign n_flag = i_ctl.capture ? o_hit : r_flag;

    always_comb begin
        n_key  = r_key;
        n_prio = r_prio;
        if (i_ctl.ins_move) begin
            if (r_flag && i_left_flag) begin
                n_key  = i_left_key;
                n_prio = i_left_prio;
            end else if (r_flag) begin
                n_key  = i_bus_key;
                n_prio = i_bus_prio;
            end
        end else if (i_ctl.del_move && r_flag) begin
            n_key  = i_right_key;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_prio <= n_prio;
    end

    assign o_key  = r_key;
    assign o_prio = r_prio;
    assign o_flag = r_flag;

endmodule

// ===== design/spq_chain.sv =====
`timescale 1ns / 1ps

module spq_chain #(
    parameter int DEPTH          = spq_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH      = spq_pkg::KEY_W_DEF,
    parameter int PRIORITY_WIDTH = spq_pkg::PRIO_W_DEF,
    parameter int CNT_WIDTH      = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  spq_pkg::t_cell_ctl        i_ctl,
    input  logic [KEY_WIDTH-1:0]      i_bus_key,
    input  logic [PRIORITY_WIDTH-1:0] i_bus_prio,
    input  logic [CNT_WIDTH-1:0]      i_count,
    output logic [KEY_WIDTH-1:0]      o_head_key,
    output logic [PRIORITY_WIDTH-1:0] o_head_prio,
    output logic                      o_found
);
    import spq_pkg::*;

    logic [KEY_WIDTH-1:0]      w_key  [DEPTH];
    logic [PRIORITY_WIDTH-1:0] w_prio [DEPTH];
    logic                      w_flag [DEPTH];
    logic                      w_hit  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_slot
        logic [KEY_WIDTH-1:0]      w_lkey;
        logic [PRIORITY_WIDTH-1:0] w_lprio;
        logic                      w_lflag;
        logic                      w_lhit;
        logic [KEY_WIDTH-1:0]      w_rkey;
        logic [PRIORITY_WIDTH-1:0] w_rprio;

        if (g == 0) begin : g_first
            assign w_lkey  = '0;
            assign w_lprio = '0;
            assign w_lflag = 1'b0;
            assign w_lhit  = 1'b0;
        end else begin : g_inner_l
            assign w_lkey  = w_key[g-1];
            assign w_lprio = w_prio[g-1];
            assign w_lflag = w_flag[g-1];
            assign w_lhit  = w_hit[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rkey  = '0;
            assign w_rprio = '0;
        end else begin : g_inner_r
            assign w_rkey  = w_key[g+1];
            assign w_rprio = w_prio[g+1];
        end

        spq_cell #(
            .KEY_WIDTH     (KEY_WIDTH),
            .PRIORITY_WIDTH(PRIORITY_WIDTH),
            .CNT_WIDTH     (CNT_WIDTH),
            .INDEX         (g)
        ) u_slot (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_bus_key   (i_bus_key),
            .i_bus_prio  (i_bus_prio),
            .i_count     (i_count),
            .i_left_key  (w_lkey),
            .i_left_prio (w_lprio),
            .i_left_flag (w_lflag),
            .i_left_hit  (w_lhit),
            .i_right_key (w_rkey),
            .i_right_prio(w_rprio),
            .o_key       (w_key[g]),
            .o_prio      (w_prio[g]),
            .o_flag      (w_flag[g]),
            .o_hit       (w_hit[g])
        );
    end

    // The last slot's flag is the OR of every match in the row.
    assign o_head_key  = w_key[0];
    assign o_head_prio = w_prio[0];
    assign o_found     = w_flag[DEPTH-1];

endmodule

// ===== dv/tb_sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps

import spq_pkg::*;

// One expected result of a command transaction.
typedef struct {
    logic [KEY_W_DEF-1:0]  key;
    logic [PRIO_W_DEF-1:0] prio;
    t_status               status;
    logic [OCC_W-1:0]      occupancy;
} t_pq_result;

// Tracks the queue contents and the results still owed by the block.
class pq_tracker;
    logic [KEY_W_DEF-1:0]  keys  [DEPTH_DEF];
    logic [PRIO_W_DEF-1:0] prios [DEPTH_DEF];
    int                    count;
    int                    errors;
    t_pq_result            pending_results[$];

    function new();
        count  = 0;
        errors = 0;
    endfunction

    function int find_key(logic [KEY_W_DEF-1:0] key);
        for (int i = 0; i < count; i++) begin
            if (keys[i] == key) return i;
        end
        return -1;
    endfunction

    function void delete_at(int pos);
        for (int i = pos; i + 1 < count; i++) begin
            keys[i]  = keys[i + 1];
            prios[i] = prios[i + 1];
        end
        count--;
    endfunction

    // Goes in front of the first entry with equal or greater priority.
    function bit place_entry(logic [KEY_W_DEF-1:0] key, logic [PRIO_W_DEF-1:0] prio);
        int pos;
        if (count >= DEPTH_DEF) return 1'b0;
        pos = 0;
        while (pos < count && prio > prios[pos]) pos++;
        for (int i = count; i > pos; i--) begin
            keys[i]  = keys[i - 1];
            prios[i] = prios[i - 1];
        end
        keys[pos]  = key;
        prios[pos] = prio;
        count++;
        return 1'b1;
    endfunction

    function void note_command(logic [FUNC_W-1:0] fn, logic [KEY_W_DEF-1:0] key,
                               logic [PRIO_W_DEF-1:0] prio);
        t_pq_result r;
        int         pos;
        r = '{key: '0, prio: '0, status: ST_OK, occupancy: '0};
        case (fn)
            FN_INSERT: begin
                if (!place_entry(key, prio)) r.status = ST_FULL;
            end
            FN_EXTRACT: begin
                if (count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.key  = keys[0];
                    r.prio = prios[0];
                    delete_at(0);
                end
            end
            FN_REMOVE: begin
                pos = find_key(key);
                if (pos < 0) r.status = ST_NOTFOUND;
                else delete_at(pos);
            end
            FN_CHANGE: begin
                pos = find_key(key);
                if (pos < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    delete_at(pos);
                    void'(place_entry(key, prio));
                end
            end
            FN_CLEAR: begin
                count = 0;
            end
            default: ;
        endcase
        r.occupancy = count[OCC_W-1:0];
        pending_results.insert(pending_results.size(), r);
    endfunction

    task report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    task check_result(logic [KEY_W_DEF-1:0] key, logic [PRIO_W_DEF-1:0] prio,
                      logic [STATUS_W-1:0] status, logic [OCC_W-1:0] occupancy);
        t_pq_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result key %h prio %h status %0d occ %0d",
                                      key, prio, status, occupancy));
            return;
        end
        want = pending_results.pop_front();
        if (key !== want.key)
            report_mismatch($sformatf("out_key %h, want %h", key, want.key));
        if (prio !== want.prio)
            report_mismatch($sformatf("out_priority %h, want %h", prio, want.prio));
        if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %s", status, want.status.name()));
        if (occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, want %0d", occupancy, want.occupancy));
    endtask
endclass

module tb_sorted_priority_queue_top;

    // About 600 command transactions in all, directed part and ignored codes included.
    localparam int ITEM_TARGET  = 600;
    // Extra wait after the last owed result has been checked, so that a stray
    // strobe would still be caught by the monitor.
    localparam int DRAIN_CYCLES = 12;
    // Even with every transaction of the slowest kind and followed by the longest
    // idle gap, the run stays well inside this limit.
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {
        PH_FILL,
        PH_MIXED,
        PH_DRAIN
    } t_phase;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    start           = 1'b0;
    logic [FUNC_W-1:0]       i_func          = '0;
    logic [KEY_W_DEF-1:0]    i_item_key      = '0;
    logic [PRIO_W_DEF-1:0]   i_item_priority = '0;
    logic                    busy;
    logic                    o_done;
    logic [KEY_W_DEF-1:0]    o_out_key;
    logic [PRIO_W_DEF-1:0]   o_out_priority;
    logic [STATUS_W-1:0]     o_status;
    logic [OCC_W-1:0]        o_occupancy;

    pq_tracker board = new();
    int        sent;
    int        cycle_count;

    sorted_priority_queue_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_item_key      (i_item_key),
        .i_item_priority (i_item_priority),
        .o_done          (o_done),
        .o_out_key       (o_out_key),
        .o_out_priority  (o_out_priority),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy)
    );

    always #1 i_clk = ~i_clk;

    // Monitor. Everything is sampled at the rising edge, before the block's
    // own nonblocking updates land, so a command transaction is seen exactly
    // at the edge that accepts it and a result at the edge that ends its
    // strobe cycle. Noting the command before checking keeps the order of
    // expectations correct even if both happen at one edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) board.note_command(i_func, i_item_key, i_item_priority);
            if (o_done) board.check_result(o_out_key, o_out_priority, o_status, o_occupancy);
        end
    end

    // Presents one command and returns at the edge where it is accepted.
    // The caller either lowers start in that same step or presents the next
    // command, so start gets one assignment per step.
    task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [KEY_W_DEF-1:0] key,
                            input logic [PRIO_W_DEF-1:0] prio);
        start           <= 1'b1;
        i_func          <= fn;
        i_item_key      <= key;
        i_item_priority <= prio;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Idle gap: start low, with junk on the payload that must be ignored.
    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) begin
            i_func          <= FUNC_W'($urandom);
            i_item_key      <= KEY_W_DEF'($urandom);
            i_item_priority <= PRIO_W_DEF'($urandom);
            @(posedge i_clk);
        end
    endtask

    // Mostly back-to-back, sometimes a short gap, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic issue(input logic [FUNC_W-1:0] fn, input logic [KEY_W_DEF-1:0] key,
                         input logic [PRIO_W_DEF-1:0] prio, input bit with_gaps);
        int g;
        send_cmd(fn, key, prio);
        sent++;
        g = with_gaps ? gap_len() : 0;
        if (g > 0) pause(g);
    endtask

    // Operation mix per phase: fill pushes the queue up to full, drain pulls
    // it back to empty, mixed keeps it wandering in between.
    function automatic logic [FUNC_W-1:0] pick_func(t_phase phase);
        int r;
        int ins, ext, rem, chg, clr;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL:  begin ins = 80; ext = 85; rem = 90; chg = 98; clr = 98; end
            PH_MIXED: begin ins = 40; ext = 65; rem = 78; chg = 93; clr = 96; end
            default:  begin ins = 15; ext = 70; rem = 82; chg = 94; clr = 96; end
        endcase
        if (r < ins) return FN_INSERT;
        if (r < ext) return FN_EXTRACT;
        if (r < rem) return FN_REMOVE;
        if (r < chg) return FN_CHANGE;
        if (r < clr) return FN_CLEAR;
        return FUNC_W'($urandom_range(FN_CLEAR + 1, (1 << FUNC_W) - 1));
    endfunction

    // Half the time a key that is already held, so removes and changes hit
    // and duplicate keys build up; otherwise a small pool or the full range.
    function automatic logic [KEY_W_DEF-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (board.count > 0 && r < 50) return board.keys[$urandom_range(0, board.count - 1)];
        if (r < 80) return KEY_W_DEF'($urandom_range(0, 15));
        return KEY_W_DEF'($urandom);
    endfunction

    // Narrow priorities give many ties; the extremes show up on their own.
    function automatic logic [PRIO_W_DEF-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return PRIO_W_DEF'($urandom_range(0, 7));
        if (r < 45) return '0;
        if (r < 50) return '1;
        return PRIO_W_DEF'($urandom);
    endfunction

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_phase phase;
        int     seg;
        int     seg_len;
        bit     with_gaps;

        sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Operations on an empty queue come first: extract
        // must flag empty, remove and change must flag a missing key.
        issue(FN_EXTRACT, 16'h0000, 16'h0000, 1'b1);
        issue(FN_REMOVE,  16'h1234, 16'h0000, 1'b0);
        issue(FN_CHANGE,  16'h1234, 16'h0042, 1'b1);
        // Field extremes, a priority tie (newest of the tie goes first) and
        // a duplicate key.
        issue(FN_INSERT,  16'hFFFF, 16'hFFFF, 1'b0);
        issue(FN_INSERT,  16'h0000, 16'h0000, 1'b0);
        issue(FN_INSERT,  16'h0005, 16'd100,  1'b1);
        issue(FN_INSERT,  16'h0006, 16'd100,  1'b0);
        issue(FN_INSERT,  16'h0005, 16'd50,   1'b0);
        issue(FN_INSERT,  16'hAAAA, 16'h5555, 1'b1);
        issue(FN_INSERT,  16'h5555, 16'hAAAA, 1'b0);
        // Remove takes the first of the two entries with key 5.
        issue(FN_REMOVE,  16'h0005, 16'h0000, 1'b0);
        // Changes move an entry to the front of its new tie group.
        issue(FN_CHANGE,  16'h0006, 16'hFFFF, 1'b1);
        issue(FN_CHANGE,  16'hFFFF, 16'h0000, 1'b0);
        // Unused operation codes must leave the queue alone.
        issue(3'd5,       16'hFFFF, 16'hFFFF, 1'b0);
        issue(3'd6,       16'h0005, 16'h0001, 1'b0);
        issue(3'd7,       16'h0000, 16'h0000, 1'b1);
        issue(FN_EXTRACT, 16'h0000, 16'h0000, 1'b0);
        issue(FN_EXTRACT, 16'h0000, 16'h0000, 1'b0);
        issue(FN_EXTRACT, 16'h0000, 16'h0000, 1'b1);
        // Clear with entries held, then extract and clear on an empty queue.
        issue(FN_CLEAR,   16'h0000, 16'h0000, 1'b0);
        issue(FN_EXTRACT, 16'h0000, 16'h0000, 1'b0);
        issue(FN_CLEAR,   16'h0000, 16'h0000, 1'b1);

        // Random part, in segments that rotate fill, mixed and drain. Fill
        // segments are long enough to reach a full queue, where inserts are
        // dropped and changes of held keys must still succeed. About a third
        // of the segments run back to back with no idle cycles. The last
        // segment is cut short so that the total lands on the target.
        seg  = 0;
        while (sent < ITEM_TARGET) begin
            phase     = t_phase'(seg % 3);
            seg_len   = (phase == PH_FILL) ? $urandom_range(80, 130) : $urandom_range(30, 100);
            if (seg_len > ITEM_TARGET - sent) seg_len = ITEM_TARGET - sent;
            with_gaps = ($urandom_range(0, 2) != 0);
            repeat (seg_len) issue(pick_func(phase), pick_key(), pick_priority(), with_gaps);
            seg++;
        end
        start <= 1'b0;

        // Wait for every owed result, then a little longer so that a stray
        // extra strobe would still be caught by the monitor.
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/spq_chain.sv
design/sorted_priority_queue_top.sv
dv/tb_sorted_priority_queue_top.sv
